FILE: design/ties_pkg.sv
// ---------------------------------------------------------------------------
// TIM image endian swapper package
// Shared types, codes and byte-swap functions for the TIM word converter.
// ---------------------------------------------------------------------------
package ties_pkg;

    // One input word of the file buffer.
    typedef struct packed {
        logic [31:0] word_in;
        logic        first_word;
    } ties_in_t;

    // One converted word with its tags.
    typedef struct packed {
        logic [31:0] word_out;
        logic [2:0]  region;
        logic [2:0]  status;
    } ties_out_t;

    // File format constants.
    localparam logic [31:0] TIM_MAGIC = 32'h0000_0010;
    localparam logic [31:0] MODE_CLUT = 32'h0000_0008;
    localparam logic [31:0] MIN_BLOCK = 32'd12;

    // Walk phases.
    localparam logic [3:0] PH_AWAIT     = 4'd0;
    localparam logic [3:0] PH_MODE      = 4'd1;
    localparam logic [3:0] PH_CLUT_SIZE = 4'd2;
    localparam logic [3:0] PH_CLUT_R0   = 4'd3;
    localparam logic [3:0] PH_CLUT_R1   = 4'd4;
    localparam logic [3:0] PH_CLUT_DATA = 4'd5;
    localparam logic [3:0] PH_IMG_SIZE  = 4'd6;
    localparam logic [3:0] PH_IMG_R0    = 4'd7;
    localparam logic [3:0] PH_IMG_R1    = 4'd8;
    localparam logic [3:0] PH_IMG_DATA  = 4'd9;
    localparam logic [3:0] PH_DONE      = 4'd10;

    // Region tags.
    localparam logic [2:0] REG_HEADER    = 3'd0;
    localparam logic [2:0] REG_CLUT_SIZE = 3'd1;
    localparam logic [2:0] REG_CLUT_RECT = 3'd2;
    localparam logic [2:0] REG_CLUT_DATA = 3'd3;
    localparam logic [2:0] REG_IMG_SIZE  = 3'd4;
    localparam logic [2:0] REG_IMG_RECT  = 3'd5;
    localparam logic [2:0] REG_IMG_DATA  = 3'd6;
    localparam logic [2:0] REG_UNTOUCHED = 3'd7;

    // Status codes.
    localparam logic [2:0] STAT_CONVERTING = 3'd0;
    localparam logic [2:0] STAT_NATIVE     = 3'd1;
    localparam logic [2:0] STAT_NOT_TIM    = 3'd2;
    localparam logic [2:0] STAT_BAD_SIZE   = 3'd3;
    localparam logic [2:0] STAT_PAST_END   = 3'd4;

    // Full byte reversal of a word.
    function automatic logic [31:0] rev32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Byte swap within each 16-bit half.
    function automatic logic [31:0] rev_halves(input logic [31:0] v);
        return {v[23:16], v[31:24], v[7:0], v[15:8]};
    endfunction

endpackage

FILE: design/tim_image_endian_swapper_unit.sv
// ---------------------------------------------------------------------------
// TIM image endian swapper unit
// Converts a TIM file streamed one 32-bit word at a time to the other byte
// order, tagging every word with its region in the file and a status.
// ---------------------------------------------------------------------------
// The block takes one word per clock cycle while the output side keeps taking
// words, and gives one result word per input word, in order: the input word is
// registered, converted by a byte swap and a small phase and count update,
// and the result is registered on the output. Each stage loads when it is
// empty or being drained, so a full rate stream runs without gaps as long as
// the output side keeps taking words. Raise first_word on the first word of
// each file buffer; it restarts the walk whatever came before.
module tim_image_endian_swapper_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    output logic                word_ready,
    input  ties_pkg::ties_in_t  word,
    output logic                result_valid,
    input  logic                result_ready,
    output ties_pkg::ties_out_t result
);
    import ties_pkg::*;

    // Input stage.
    logic        in_valid_reg;
    ties_in_t    in_data_reg;

    // Output stage.
    logic        out_valid_reg;
    ties_out_t   out_data_reg;
    ties_out_t   out_data_next;

    // Walk state.
    logic [3:0]  phase_reg;
    logic [3:0]  phase_next;
    logic [29:0] words_left_reg;
    logic [29:0] words_left_next;
    logic [2:0]  final_status_reg;
    logic [2:0]  final_status_next;

    // Conversion helpers.
    logic [31:0] w;
    logic [31:0] w_rev;
    logic [31:0] w_halves;
    logic [31:0] size_less_min;
    logic        size_bad;
    logic        out_load;
    logic        advance;

    // Handshake: the output register loads when empty or being drained.
    assign out_load   = !out_valid_reg || result_ready;
    assign advance    = in_valid_reg && out_load;
    assign word_ready = !in_valid_reg || out_load;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Byte swaps and size check on the registered word.
    assign w             = in_data_reg.word_in;
    assign w_rev         = rev32(w);
    assign w_halves      = rev_halves(w);
    assign size_less_min = w_rev - MIN_BLOCK;
    assign size_bad      = (w_rev < MIN_BLOCK) || (w_rev[1:0] != 2'b00);

    // Next walk state and converted word.
    always_comb
    begin
        phase_next             = phase_reg;
        words_left_next        = words_left_reg;
        final_status_next      = final_status_reg;
        out_data_next.word_out = w;
        out_data_next.region   = REG_UNTOUCHED;
        out_data_next.status   = STAT_PAST_END;

        if (in_data_reg.first_word)
        begin
            words_left_next = '0;
            if (w == TIM_MAGIC)
            begin
                phase_next           = PH_DONE;
                final_status_next    = STAT_NATIVE;
                out_data_next.status = STAT_NATIVE;
            end
            else if (w_rev != TIM_MAGIC)
            begin
                phase_next           = PH_DONE;
                final_status_next    = STAT_NOT_TIM;
                out_data_next.status = STAT_NOT_TIM;
            end
            else
            begin
                phase_next             = PH_MODE;
                final_status_next      = STAT_CONVERTING;
                out_data_next.word_out = w_rev;
                out_data_next.region   = REG_HEADER;
                out_data_next.status   = STAT_CONVERTING;
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_MODE:
                begin
                    out_data_next.word_out = w_rev;
                    out_data_next.region   = REG_HEADER;
                    out_data_next.status   = STAT_CONVERTING;
                    phase_next = ((w_rev & MODE_CLUT) != '0) ? PH_CLUT_SIZE : PH_IMG_SIZE;
                end
                PH_CLUT_SIZE, PH_IMG_SIZE:
                begin
                    out_data_next.word_out = w_rev;
                    out_data_next.region   = (phase_reg == PH_CLUT_SIZE) ? REG_CLUT_SIZE
                                                                         : REG_IMG_SIZE;
                    if (size_bad)
                    begin
                        phase_next           = PH_DONE;
                        final_status_next    = STAT_BAD_SIZE;
                        out_data_next.status = STAT_BAD_SIZE;
                    end
                    else
                    begin
                        words_left_next      = size_less_min[31:2];
                        phase_next           = (phase_reg == PH_CLUT_SIZE) ? PH_CLUT_R0
                                                                           : PH_IMG_R0;
                        out_data_next.status = STAT_CONVERTING;
                    end
                end
                PH_CLUT_R0, PH_IMG_R0:
                begin
                    out_data_next.word_out = w_halves;
                    out_data_next.region   = (phase_reg == PH_CLUT_R0) ? REG_CLUT_RECT
                                                                       : REG_IMG_RECT;
                    out_data_next.status   = STAT_CONVERTING;
                    phase_next = (phase_reg == PH_CLUT_R0) ? PH_CLUT_R1 : PH_IMG_R1;
                end
                PH_CLUT_R1, PH_IMG_R1:
                begin
                    out_data_next.word_out = w_halves;
                    out_data_next.region   = (phase_reg == PH_CLUT_R1) ? REG_CLUT_RECT
                                                                       : REG_IMG_RECT;
                    out_data_next.status   = STAT_CONVERTING;
                    if (words_left_reg != '0)
                    begin
                        phase_next = (phase_reg == PH_CLUT_R1) ? PH_CLUT_DATA : PH_IMG_DATA;
                    end
                    else if (phase_reg == PH_CLUT_R1)
                    begin
                        phase_next = PH_IMG_SIZE;
                    end
                    else
                    begin
                        phase_next        = PH_DONE;
                        final_status_next = STAT_PAST_END;
                    end
                end
                PH_CLUT_DATA, PH_IMG_DATA:
                begin
                    out_data_next.word_out = w_halves;
                    out_data_next.region   = (phase_reg == PH_CLUT_DATA) ? REG_CLUT_DATA
                                                                         : REG_IMG_DATA;
                    out_data_next.status   = STAT_CONVERTING;
                    if (words_left_reg != '0)
                    begin
                        words_left_next = words_left_reg - 30'd1;
                    end
                    // The last data word closes the block.
                    if (words_left_reg <= 30'd1)
                    begin
                        if (phase_reg == PH_CLUT_DATA)
                        begin
                            phase_next = PH_IMG_SIZE;
                        end
                        else
                        begin
                            phase_next        = PH_DONE;
                            final_status_next = STAT_PAST_END;
                        end
                    end
                end
                PH_DONE:
                begin
                    out_data_next.status = final_status_reg;
                end
                default:
                begin
                    // No file started yet: the word passes as past the end.
                    out_data_next.status = STAT_PAST_END;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_AWAIT;
            words_left_reg   <= '0;
            final_status_reg <= STAT_CONVERTING;
        end
        else
        begin
            if (word_ready)
            begin
                in_valid_reg <= word_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                phase_reg        <= phase_next;
                words_left_reg   <= words_left_next;
                final_status_reg <= final_status_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (word_ready && word_valid)
        begin
            in_data_reg <= word;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // The walk never reaches an unused phase code.
    assert property (@(posedge clk) disable iff (!rst_n) phase_reg <= PH_DONE)
        else $error("phase register holds an unused code");

    // A data phase always has at least one word still to convert.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CLUT_DATA || phase_reg == PH_IMG_DATA) |-> words_left_reg != '0)
        else $error("data phase entered with no words left");

    // A bad size is only ever reported on a size word or on untouched words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == STAT_BAD_SIZE
         && out_data_reg.region != REG_UNTOUCHED)
        |-> (out_data_reg.region == REG_CLUT_SIZE || out_data_reg.region == REG_IMG_SIZE))
        else $error("bad size status on a region other than a size word");

    // Input back-pressure only arises when both stages are full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !word_ready |-> (in_valid_reg && out_valid_reg && !result_ready))
        else $error("input stalled while a stage could move");

endmodule

FILE: tb/tb_tim_image_endian_swapper_unit.sv
// ---------------------------------------------------------------------------
// TIM image endian swapper unit testbench
// Streams TIM file buffers through the unit and checks every converted word,
// its region tag and its status against a predictor of the file walk. A
// short directed run covers the special files, then a long random run of
// mostly well-formed files with truncated, malformed and noise buffers mixed
// in. Both handshake sides idle at random, with stretches at full rate.
// ---------------------------------------------------------------------------
module tb_tim_image_endian_swapper_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ties_pkg::*;

    localparam int unsigned RANDOM_WORDS = 800;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      word_valid = 1'b0;
    logic      word_ready;
    ties_in_t  word = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    ties_out_t result;

    // Words waiting to be offered, and converted words still to arrive.
    ties_in_t    pending_words[$];
    ties_out_t   expected_words[$];
    int unsigned stim_count = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;

    // Predictor copy of the file walk.
    logic [3:0]  tim_phase = PH_AWAIT;
    logic [29:0] data_left = '0;
    logic        clut_present = 1'b0;
    logic [2:0]  tail_status = STAT_CONVERTING;

    tim_image_endian_swapper_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_ready   (word_ready),
        .word         (word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] flip_bytes(input logic [31:0] v);
        return {<<8{v}};
    endfunction

    function automatic logic [31:0] flip_halves(input logic [31:0] v);
        return {v[23:16], v[31:24], v[7:0], v[15:8]};
    endfunction

    // Idle cycles before the next word; none during a full rate stretch.
    function automatic int unsigned idle_draw(input bit steady);
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    // After the last word of a block: on to the image, or past the end.
    function automatic void end_of_block(input logic in_clut);
        if (in_clut)
        begin
            tim_phase = PH_IMG_SIZE;
        end
        else
        begin
            tim_phase = PH_DONE;
            tail_status = STAT_PAST_END;
        end
    endfunction

    // Converts one word and advances the predicted walk.
    function automatic ties_out_t convert_word(input ties_in_t item);
        ties_out_t   r;
        logic [31:0] w;
        logic [31:0] s;
        logic        in_clut;
        w = item.word_in;
        r.word_out = w;
        r.region = REG_UNTOUCHED;
        r.status = STAT_PAST_END;
        if (item.first_word)
        begin
            data_left = '0;
            clut_present = 1'b0;
            if (w == TIM_MAGIC)
            begin
                tim_phase = PH_DONE;
                tail_status = STAT_NATIVE;
                r.status = STAT_NATIVE;
            end
            else if (flip_bytes(w) != TIM_MAGIC)
            begin
                tim_phase = PH_DONE;
                tail_status = STAT_NOT_TIM;
                r.status = STAT_NOT_TIM;
            end
            else
            begin
                tim_phase = PH_MODE;
                tail_status = STAT_CONVERTING;
                r = '{flip_bytes(w), REG_HEADER, STAT_CONVERTING};
            end
            return r;
        end
        case (tim_phase)
            PH_MODE:
            begin
                s = flip_bytes(w);
                clut_present = (s & MODE_CLUT) != '0;
                tim_phase = clut_present ? PH_CLUT_SIZE : PH_IMG_SIZE;
                r = '{s, REG_HEADER, STAT_CONVERTING};
            end
            PH_CLUT_SIZE, PH_IMG_SIZE:
            begin
                in_clut = (tim_phase == PH_CLUT_SIZE);
                s = flip_bytes(w);
                r.word_out = s;
                r.region = in_clut ? REG_CLUT_SIZE : REG_IMG_SIZE;
                if (s < MIN_BLOCK || s[1:0] != 2'b00)
                begin
                    tim_phase = PH_DONE;
                    tail_status = STAT_BAD_SIZE;
                    r.status = STAT_BAD_SIZE;
                end
                else
                begin
                    data_left = 30'((s - MIN_BLOCK) >> 2);
                    tim_phase = in_clut ? PH_CLUT_R0 : PH_IMG_R0;
                    r.status = STAT_CONVERTING;
                end
            end
            PH_CLUT_R0, PH_IMG_R0:
            begin
                in_clut = (tim_phase == PH_CLUT_R0);
                r = '{flip_halves(w), in_clut ? REG_CLUT_RECT : REG_IMG_RECT, STAT_CONVERTING};
                tim_phase = in_clut ? PH_CLUT_R1 : PH_IMG_R1;
            end
            PH_CLUT_R1, PH_IMG_R1:
            begin
                in_clut = (tim_phase == PH_CLUT_R1);
                r = '{flip_halves(w), in_clut ? REG_CLUT_RECT : REG_IMG_RECT, STAT_CONVERTING};
                if (data_left == '0)
                    end_of_block(in_clut);
                else
                    tim_phase = in_clut ? PH_CLUT_DATA : PH_IMG_DATA;
            end
            PH_CLUT_DATA, PH_IMG_DATA:
            begin
                in_clut = (tim_phase == PH_CLUT_DATA);
                r = '{flip_halves(w), in_clut ? REG_CLUT_DATA : REG_IMG_DATA, STAT_CONVERTING};
                if (data_left != '0)
                    data_left = data_left - 30'd1;
                if (data_left == '0)
                    end_of_block(in_clut);
            end
            PH_DONE:
            begin
                r.status = tail_status;
            end
            default:
            begin
                // No file started yet: untouched, past the end.
            end
        endcase
        return r;
    endfunction

    task automatic push_word(input logic [31:0] w, input logic first);
        ties_in_t item;
        item.word_in = w;
        item.first_word = first;
        pending_words.push_back(item);
        stim_count++;
    endtask

    // A TIM file with sound blocks, sometimes cut short by the next file.
    task automatic send_good_file();
        logic [31:0] mode;
        logic [31:0] size;
        int unsigned body;
        bit          cut;
        mode = $urandom();
        mode[3] = 1'($urandom_range(0, 1));
        push_word(flip_bytes(TIM_MAGIC), 1'b1);
        push_word(flip_bytes(mode), 1'b0);
        for (int blk = mode[3] ? 0 : 1; blk < 2; blk++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                // A huge block, always abandoned well before its end.
                size = $urandom() | 32'h0000_0100;
                size[1:0] = 2'b00;
                body = $urandom_range(0, 6);
                cut = 1'b1;
            end
            else
            begin
                size = MIN_BLOCK + 4 * $urandom_range(0, 6);
                body = 2 + (size - MIN_BLOCK) / 4;
                cut = ($urandom_range(0, 9) == 0);
                if (cut)
                    body = $urandom_range(0, body - 1);
            end
            push_word(flip_bytes(size), 1'b0);
            repeat (body) push_word($urandom(), 1'b0);
            if (cut)
                return;
        end
        repeat ($urandom_range(0, 3)) push_word($urandom(), 1'b0);
    endtask

    // A TIM file that stops on a malformed block size.
    task automatic send_bad_file();
        logic [31:0] mode;
        logic [31:0] size;
        mode = $urandom();
        push_word(flip_bytes(TIM_MAGIC), 1'b1);
        push_word(flip_bytes(mode), 1'b0);
        if (mode[3] && $urandom_range(0, 1) == 1)
        begin
            size = MIN_BLOCK + 4 * $urandom_range(0, 3);
            push_word(flip_bytes(size), 1'b0);
            repeat (2 + (size - MIN_BLOCK) / 4) push_word($urandom(), 1'b0);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            size = $urandom_range(0, 11);
        end
        else
        begin
            size = $urandom();
            if (size[1:0] == 2'b00)
                size[0] = 1'b1;
        end
        push_word(flip_bytes(size), 1'b0);
        repeat ($urandom_range(0, 3)) push_word($urandom(), 1'b0);
    endtask

    // Stimulus, reset and the end of the run.
    initial
    begin
        int unsigned pick;

        // Words before any file has started.
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        // A buffer already in native order.
        push_word(TIM_MAGIC, 1'b1);
        push_word(32'h1234_5678, 1'b0);
        // Buffers that are not TIM files.
        push_word(32'h0000_0000, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b1);
        // Palette with an empty data block, then a one-word image, then a tail.
        push_word(flip_bytes(TIM_MAGIC), 1'b1);
        push_word(flip_bytes(MODE_CLUT), 1'b0);
        push_word(flip_bytes(MIN_BLOCK), 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(flip_bytes(MIN_BLOCK + 4), 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hA5C3_0FF0, 1'b0);
        push_word(32'hDEAD_BEEF, 1'b0);
        // Image size below the minimum but a multiple of four.
        push_word(flip_bytes(TIM_MAGIC), 1'b1);
        push_word(32'h0000_0000, 1'b0);
        push_word(flip_bytes(32'd8), 1'b0);
        push_word(32'h0BAD_0BAD, 1'b0);
        // Image size that is not a multiple of four.
        push_word(flip_bytes(TIM_MAGIC), 1'b1);
        push_word(32'hF7FF_FFFF, 1'b0);
        push_word(flip_bytes(32'd13), 1'b0);

        // Random files, mostly well formed.
        while (stim_count < 24 + RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                send_good_file();
            end
            else if (pick < 75)
            begin
                send_bad_file();
            end
            else if (pick < 85)
            begin
                push_word(($urandom_range(0, 1) == 1) ? TIM_MAGIC : $urandom(), 1'b1);
                repeat ($urandom_range(0, 3)) push_word($urandom(), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_word($urandom(), $urandom_range(0, 3) == 0);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || word_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Driver: offers the pending words and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid <= 1'b0;
            word <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (word_valid && word_ready)
            begin
                expected_words.push_back(convert_word(word));
                words_sent = words_sent + 1;
            end
            if (!word_valid || word_ready)
            begin
                if (send_wait != 0)
                begin
                    word_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pending_words.size() != 0)
                begin
                    word <= pending_words.pop_front();
                    word_valid <= 1'b1;
                    send_wait <= idle_draw((words_sent / 97) % 4 == 0);
                end
                else
                begin
                    word_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results with random stalls and checks each field.
    always @(posedge clk or negedge rst_n)
    begin
        ties_out_t   want;
        int unsigned d;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_wait <= 0;
        end
        else if (result_valid && result_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: result with no word pending, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (result.word_out !== want.word_out)
                begin
                    $display("%0t: word_out expected %h actual %h",
                             $time, want.word_out, result.word_out);
                    error_count++;
                end
                if (result.region !== want.region)
                begin
                    $display("%0t: region expected %0d actual %0d",
                             $time, want.region, result.region);
                    error_count++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, result.status);
                    error_count++;
                end
            end
            words_checked = words_checked + 1;
            d = idle_draw((words_checked / 83) % 4 == 2);
            result_ready <= (d == 0);
            recv_wait <= d;
        end
        else if (recv_wait != 0)
        begin
            recv_wait <= recv_wait - 1;
            result_ready <= (recv_wait == 1);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words outstanding",
                     $time, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
